// File: rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// Cell reference parser package
// Shared types, grammar phase codes, status codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

  // One character request
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } crp_in_t;

  // One parse result
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] column_index;
    logic [19:0] row_index;
  } crp_out_t;

  // Running parse state
  typedef struct packed {
    logic [2:0]  parse_phase;
    logic [14:0] column_value;
    logic [20:0] row_value;
    logic [1:0]  error_code;
  } crp_state_t;

  // Grammar positions
  localparam logic [2:0] PhStart = 3'd0;  // nothing seen
  localparam logic [2:0] PhLead  = 3'd1;  // leading '$'
  localparam logic [2:0] PhLet   = 3'd2;  // in letters
  localparam logic [2:0] PhMidNl = 3'd3;  // '$' with no letters before it
  localparam logic [2:0] PhMid   = 3'd4;  // '$' after letters
  localparam logic [2:0] PhDigNl = 3'd5;  // digits with no letters
  localparam logic [2:0] PhDig   = 3'd6;  // digits after letters

  // Status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFormat = 2'd1;
  localparam logic [1:0] StRange  = 2'd2;

  // Register indexes
  localparam logic CfgColumnLimit = 1'b0;
  localparam logic CfgRowLimit    = 1'b1;

  // Hard caps so that an ok result fits the output fields
  localparam logic [14:0] ColCap = 15'd16384;
  localparam logic [20:0] RowCap = 21'd1048576;

  // Characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharA      = 8'h41;
  localparam logic [7:0] CharZ      = 8'h5A;
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char9      = 8'h39;

endpackage

`default_nettype wire

// File: rtl/cell_reference_parser.sv
// ----------------------------------------------------------------------------
// Cell reference parser
// Parses a spreadsheet cell reference one character per request into a
// zero-based column and row with a status code.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless a stalled result holds it off;
//   it updates the phase and column or row accumulator (constant multiply-add).
// Result: the result appears on the output register in the cycle after the
//   request carrying the last character is accepted.
// Reset: asynchronous, active low; clears the parse state and output valid,
//   and sets the limits to 16384 columns and 1048576 rows.
`default_nettype none

module cell_reference_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  // character requests
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crp_pkg::crp_in_t  in_data_i,
  // results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crp_pkg::crp_out_t out_data_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [20:0]       cfg_data_i
);
  import crp_pkg::*;

  // limit registers
  logic [14:0] column_limit_q;
  logic [20:0] row_limit_q;

  // parse state
  crp_state_t state_q, state_d;
  crp_state_t step_state;
  crp_out_t   step_result;

  // output register
  logic     out_valid_q, out_valid_d;
  crp_out_t out_data_q;

  logic in_accept;
  logic out_accept;

  // The output register frees itself in the cycle it is taken, so a request
  // is only held off while a result sits there and downstream is stalling.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_q & ~out_stall_i;

  // Configuration: the user must write only when idle; the block does not enforce it. No handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_limit_q <= ColCap;
      row_limit_q    <= RowCap;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgColumnLimit: column_limit_q <= cfg_data_i[14:0];
        CfgRowLimit:    row_limit_q    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Grammar and accumulator update for the incoming character
  crp_step u_step (
    .state_i        (state_q),
    .char_code_i    (in_data_i.char_code),
    .column_limit_i (column_limit_q),
    .row_limit_i    (row_limit_q),
    .state_o        (step_state),
    .result_o       (step_result)
  );

  // On the last character the state clears for the next reference
  always_comb begin
    state_d = state_q;
    if (in_accept) begin
      if (in_data_i.is_last) begin
        state_d = '{parse_phase: PhStart, column_value: '0, row_value: '0,
                    error_code: StOk};
      end else begin
        state_d = step_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{parse_phase: PhStart, column_value: '0, row_value: '0,
                   error_code: StOk};
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: loads on the last character, holds while stalled
  assign out_valid_d = (in_accept & in_data_i.is_last) | (out_valid_q & ~out_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && in_data_i.is_last) begin
      out_data_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a last character always leaves a result waiting
  a_last_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.is_last) |=> out_valid_q
  ) else $error("last character did not produce a result");

  // a non-last character never creates a result out of nothing
  a_no_spurious_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && in_accept && !in_data_i.is_last) |=> !out_valid_q
  ) else $error("result raised without a last character");

  // the parse state is clean after every reference
  a_clear_after_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.is_last) |=>
      (state_q.parse_phase == PhStart) && (state_q.error_code == StOk) &&
      (state_q.column_value == 15'd0) && (state_q.row_value == 21'd0)
  ) else $error("parse state not cleared after last character");

  // an error result carries zero indices
  a_error_zero_index: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.status != StOk)) |->
      (out_data_q.column_index == 14'd0) && (out_data_q.row_index == 20'd0)
  ) else $error("error result with nonzero indices");

endmodule

`default_nettype wire

// File: rtl/crp_step.sv
// ----------------------------------------------------------------------------
// Cell reference parser step
// Applies one character to the parse state and forms the result it would give.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_step (
  input  crp_pkg::crp_state_t state_i,
  input  logic [7:0]          char_code_i,
  input  logic [14:0]         column_limit_i,
  input  logic [20:0]         row_limit_i,
  output crp_pkg::crp_state_t state_o,
  output crp_pkg::crp_out_t   result_o
);
  import crp_pkg::*;

  logic        is_letter;
  logic        is_digit;
  logic        is_dollar;
  logic        take_letter;
  logic        take_digit;
  logic [2:0]  digit_phase;
  logic [14:0] col_lim;
  logic [20:0] row_lim;
  logic [7:0]  letter_off;
  logic [7:0]  digit_off;
  logic [18:0] col_v;
  logic [24:0] row_v;
  crp_state_t  nxt;

  assign is_letter = (char_code_i >= CharA) && (char_code_i <= CharZ);
  assign is_digit  = (char_code_i >= Char0) && (char_code_i <= Char9);
  assign is_dollar = (char_code_i == CharDollar);

  assign col_lim = (column_limit_i > ColCap) ? ColCap : column_limit_i;
  assign row_lim = (row_limit_i > RowCap) ? RowCap : row_limit_i;

  assign letter_off = char_code_i - CharA;
  assign digit_off  = char_code_i - Char0;

  // bijective base 26 and plain base 10 accumulators
  assign col_v = 19'(state_i.column_value) * 19'd26 + 19'(letter_off) + 19'd1;
  assign row_v = 25'(state_i.row_value) * 25'd10 + 25'(digit_off);

  always_comb begin
    nxt         = state_i;
    take_letter = 1'b0;
    take_digit  = 1'b0;
    digit_phase = PhDigNl;

    if (state_i.error_code == StOk) begin
      unique case (state_i.parse_phase)
        PhStart: begin
          if (is_dollar) nxt.parse_phase = PhLead;
          else if (is_letter) take_letter = 1'b1;
          else if (is_digit) take_digit = 1'b1;
          else nxt.error_code = StFormat;
        end
        PhLead: begin
          if (is_dollar) nxt.parse_phase = PhMidNl;
          else if (is_letter) take_letter = 1'b1;
          else if (is_digit) take_digit = 1'b1;
          else nxt.error_code = StFormat;
        end
        PhLet: begin
          digit_phase = PhDig;
          if (is_dollar) nxt.parse_phase = PhMid;
          else if (is_letter) take_letter = 1'b1;
          else if (is_digit) take_digit = 1'b1;
          else nxt.error_code = StFormat;
        end
        PhMidNl, PhDigNl: begin
          if (is_digit) take_digit = 1'b1;
          else nxt.error_code = StFormat;
        end
        PhMid, PhDig: begin
          digit_phase = PhDig;
          if (is_digit) take_digit = 1'b1;
          else nxt.error_code = StFormat;
        end
        default: nxt.error_code = StFormat;  // unused phase: nothing fits
      endcase
    end

    if (take_letter) begin
      nxt.parse_phase = PhLet;
      if (col_v > 19'(col_lim)) nxt.error_code = StRange;
      else nxt.column_value = col_v[14:0];
    end

    if (take_digit) begin
      nxt.parse_phase = digit_phase;
      if (row_v > 25'(row_lim)) nxt.error_code = StRange;
      else nxt.row_value = row_v[20:0];
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.status       = nxt.error_code;
    result_o.column_index = '0;
    result_o.row_index    = '0;
    if (nxt.error_code == StOk) begin
      if ((nxt.parse_phase != PhDig) || (nxt.column_value == 15'd0) ||
          (nxt.row_value == 21'd0)) begin
        result_o.status = StFormat;
      end else begin
        result_o.column_index = 14'(nxt.column_value - 15'd1);
        result_o.row_index    = 20'(nxt.row_value - 21'd1);
      end
    end
  end

endmodule

`default_nettype wire
